>>> hw/rtl/dns_pkg.sv
// Shared types and constants for the decimal number scanner.
// No dependencies; used by every module under hw/rtl except dns_checker.
package dns_pkg;

	localparam int CHAR_W      = 8;
	localparam int MANT_W      = 64;
	localparam int DEXP_W      = 16;
	localparam int DCNT_W      = 5;
	localparam int FRAC_W      = 16;
	localparam int EXP_ACC_W   = 14;
	localparam int EXP_SUM_W   = FRAC_W + 2;
	localparam int MANT_DIGITS = 19;
	localparam int EXP_LIMIT   = 9999;
	localparam int OUT_W       = 88;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;
	localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_INT   = 2'd1,
		PH_FRAC  = 2'd2,
		PH_EXP   = 2'd3
	} phase_t;

	typedef struct packed {
		logic              last_char;
		logic [CHAR_W-1:0] character;
	} in_word_t;

	typedef struct packed {
		phase_t                 phase;
		logic                   sign_neg;
		logic [MANT_W-1:0]      digit_acc;
		logic [DCNT_W-1:0]      digits_kept;
		logic [FRAC_W-1:0]      frac_digits;
		logic [FRAC_W-1:0]      int_dropped;
		logic                   exp_neg;
		logic [EXP_ACC_W-1:0]   exp_acc;
		logic                   exp_sign_allowed;
		logic                   error_seen;
		logic                   drop_seen;
	} scan_state_t;

	typedef struct packed {
		logic                     inexact;
		logic                     malformed;
		logic signed [DEXP_W-1:0] dec_exponent;
		logic [MANT_W-1:0]        mantissa;
		logic                     negative;
	} result_t;

endpackage

>>> hw/rtl/dns_in_reg.sv
// Input register stage: holds one character word until the scanner takes it.
// Depends on dns_pkg.
module dns_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              out_ready,
	output logic              step,
	output dns_pkg::in_word_t word_s1
);

	logic valid_s1;

	// a last word needs room in the output register, others always pass
	assign step     = valid_s1 && (!word_s1.last_char || out_ready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1.character <= s_tdata;
			word_s1.last_char <= s_tlast;
		end
	end

endmodule

>>> hw/rtl/dns_scan.sv
// Scanner state and per-character update, plus the final exponent sum.
// Depends on dns_pkg.
module dns_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  dns_pkg::in_word_t word_s1,
	output dns_pkg::result_t  result
);

	dns_pkg::scan_state_t st_q;
	dns_pkg::scan_state_t nx;

	logic [dns_pkg::CHAR_W-1:0]    c;
	logic                          is_digit;
	logic [3:0]                    d;
	logic                          stop;
	dns_pkg::phase_t               ph;
	logic                          in_frac;
	logic [dns_pkg::MANT_W-1:0]    acc10;
	logic [dns_pkg::EXP_SUM_W-1:0] exp10;

	logic signed [dns_pkg::EXP_SUM_W-1:0] ea;
	logic signed [dns_pkg::EXP_SUM_W-1:0] esum;

	assign c        = word_s1.character;
	assign is_digit = (c >= dns_pkg::CH_ZERO) && (c <= dns_pkg::CH_NINE);
	assign d        = is_digit ? c[3:0] : 4'd0;
	assign acc10    = (st_q.digit_acc << 3) + (st_q.digit_acc << 1)
	                  + {{(dns_pkg::MANT_W-4){1'b0}}, d};
	assign exp10    = ({4'b0, st_q.exp_acc} << 3) + ({4'b0, st_q.exp_acc} << 1)
	                  + {{(dns_pkg::EXP_SUM_W-4){1'b0}}, d};

	// next state for one character
	always_comb begin
		nx      = st_q;
		ph      = st_q.phase;
		stop    = 1'b0;
		in_frac = 1'b0;
		if (ph == dns_pkg::PH_START) begin
			nx.phase = dns_pkg::PH_INT;
			ph       = dns_pkg::PH_INT;
			if (c == dns_pkg::CH_MINUS) begin
				nx.sign_neg = 1'b1;
				stop        = 1'b1;
			end
		end
		if (!stop) begin
			if (ph == dns_pkg::PH_EXP) begin
				if (is_digit) begin
					nx.exp_acc = (exp10 > dns_pkg::EXP_SUM_W'(dns_pkg::EXP_LIMIT)) ?
					             dns_pkg::EXP_ACC_W'(dns_pkg::EXP_LIMIT) :
					             exp10[dns_pkg::EXP_ACC_W-1:0];
					nx.exp_sign_allowed = 1'b0;
				end else if (st_q.exp_sign_allowed &&
				             (c == dns_pkg::CH_PLUS || c == dns_pkg::CH_MINUS)) begin
					if (c == dns_pkg::CH_MINUS) begin
						nx.exp_neg = 1'b1;
					end
					nx.exp_sign_allowed = 1'b0;
				end else begin
					nx.error_seen = 1'b1;
				end
			end else if (is_digit) begin
				in_frac = (ph == dns_pkg::PH_FRAC);
				if (st_q.digit_acc == '0 && d == 4'd0) begin
					// leading zero: no capacity used
					if (in_frac && st_q.frac_digits != '1) begin
						nx.frac_digits = st_q.frac_digits + 1'b1;
					end
				end else if (st_q.digits_kept < dns_pkg::DCNT_W'(dns_pkg::MANT_DIGITS)) begin
					nx.digit_acc   = acc10;
					nx.digits_kept = st_q.digits_kept + 1'b1;
					if (in_frac && st_q.frac_digits != '1) begin
						nx.frac_digits = st_q.frac_digits + 1'b1;
					end
				end else begin
					if (!in_frac && st_q.int_dropped != '1) begin
						nx.int_dropped = st_q.int_dropped + 1'b1;
					end
					if (d != 4'd0) begin
						nx.drop_seen = 1'b1;
					end
				end
			end else if (c == dns_pkg::CH_POINT && ph == dns_pkg::PH_INT) begin
				nx.phase = dns_pkg::PH_FRAC;
			end else if (c == dns_pkg::CH_E_LO || c == dns_pkg::CH_E_UP) begin
				nx.phase            = dns_pkg::PH_EXP;
				nx.exp_sign_allowed = 1'b1;
			end else begin
				nx.error_seen = 1'b1;
			end
		end
	end

	// result fields from the updated state
	always_comb begin
		ea   = {{(dns_pkg::EXP_SUM_W-dns_pkg::EXP_ACC_W){1'b0}}, nx.exp_acc};
		esum = (nx.exp_neg ? -ea : ea)
		       + $signed({2'b00, nx.int_dropped})
		       - $signed({2'b00, nx.frac_digits});
		result.negative  = nx.sign_neg;
		result.mantissa  = nx.digit_acc;
		result.malformed = nx.error_seen ||
		                   (nx.phase == dns_pkg::PH_EXP && nx.exp_sign_allowed);
		result.inexact   = nx.drop_seen;
		if (esum > dns_pkg::EXP_SUM_W'(32767)) begin
			result.dec_exponent = 16'sh7FFF;
		end else if (esum < -(dns_pkg::EXP_SUM_W'(32768))) begin
			result.dec_exponent = 16'sh8000;
		end else begin
			result.dec_exponent = esum[dns_pkg::DEXP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			// the final character returns the scanner to its start
			st_q <= word_s1.last_char ? '0 : nx;
		end
	end

endmodule

>>> hw/rtl/dns_out_reg.sv
// Output register: holds a finished result until the receiver takes it.
// Depends on dns_pkg.
module dns_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  dns_pkg::result_t            result,
	output logic                        out_ready,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [dns_pkg::OUT_W-1:0]   m_tdata
);

	logic             valid_q;
	dns_pkg::result_t res_q;

	assign out_ready = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tdata   = {{(dns_pkg::OUT_W - $bits(dns_pkg::result_t)){1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

endmodule

>>> hw/rtl/decimal_number_scanner.sv
// Top level of the decimal number scanner.
// Depends on dns_pkg, dns_in_reg, dns_scan and dns_out_reg.
//
// Input stream: one ASCII character of a literal such as -12.5e+3 per word,
// s_tlast on its final character. Output stream: one word per literal, the
// value being (-1)^negative * mantissa * 10^dec_exponent, with flags for a
// malformed literal and for nonzero digits dropped past 19 significant ones.
// Throughput: one character per cycle unless a final character waits on a
// stalled output, held by the combinational update of the scanner state
// (mantissa times ten plus digit, exponent sum). A final character passes
// through the input and the output register before it shows on m_tvalid.
// Reset clears the scanner to the start of a literal and empties both
// registers. When the receiver stalls, non-final characters keep flowing;
// a final character waits in the input register while the output register
// holds an untaken result, and s_tready drops only then.
module decimal_number_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] character
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata    // [0] negative, [64:1] mantissa,
	                               // [80:65] dec_exponent, [81] malformed,
	                               // [82] inexact, [87:83] zero
);

	logic              step;
	logic              out_ready;
	dns_pkg::in_word_t word_s1;
	dns_pkg::result_t  result;

	dns_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.out_ready (out_ready),
		.step      (step),
		.word_s1   (word_s1)
	);

	dns_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.word_s1 (word_s1),
		.result  (result)
	);

	dns_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && word_s1.last_char),
		.result    (result),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> hw/rtl/dns_checker.sv
// Port-level checks for the decimal number scanner, bound to the top level.
// Depends on decimal_number_scanner.
module dns_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata
);

	// a stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// a receiver that takes words never stalls the character stream
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output was ready");

	// pad bits above the result fields stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[87:83] == 5'd0)
		else $error("pad bits of result word not zero");

	// a fresh result follows the acceptance of a final character
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result appeared without a final character");

endmodule

bind decimal_number_scanner dns_checker u_chk (.*);

>>> tb/decimal_number_scanner_test.sv
// Self-checking bench for decimal_number_scanner: streams literals in one
// character per word and checks each result word against its own scanner model.
// Depends on dns_pkg and the decimal_number_scanner RTL.
module decimal_number_scanner_test;
	import dns_pkg::*;

	localparam int CALM_ITEMS = 150;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       hold;   // wait for all results before sending this word
	} feed_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;

	feed_t      feed_q[$];
	result_t    result_q[$];
	logic [7:0] lit_buf[$];
	int         mismatch_count = 0;
	logic       quiet_tail = 1'b0;

	// scanner model state
	phase_t      scan_mode;
	logic        minus_lead;
	logic [63:0] mant_acc;
	int          kept_cnt;
	int          frac_cnt;
	int          drop_cnt;
	logic        exp_minus;
	int          exp_val;
	logic        exp_sign_ok;
	logic        bad_seen;
	logic        lost_seen;

	decimal_number_scanner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_scan();
		scan_mode = PH_START;
		minus_lead = 1'b0;
		mant_acc = 64'd0;
		kept_cnt = 0;
		frac_cnt = 0;
		drop_cnt = 0;
		exp_minus = 1'b0;
		exp_val = 0;
		exp_sign_ok = 1'b0;
		bad_seen = 1'b0;
		lost_seen = 1'b0;
	endfunction

	function automatic void add_mant_digit(input int d, input bit in_frac);
		if (mant_acc == 64'd0 && d == 0) begin
			// leading zero: costs no capacity, in a fraction still shifts the point
			if (in_frac && frac_cnt < 65535) frac_cnt++;
		end else if (kept_cnt < MANT_DIGITS) begin
			mant_acc = mant_acc * 64'd10 + 64'(d);
			kept_cnt++;
			if (in_frac && frac_cnt < 65535) frac_cnt++;
		end else begin
			if (!in_frac && drop_cnt < 65535) drop_cnt++;
			if (d != 0) lost_seen = 1'b1;
		end
	endfunction

	// Advance the model by one character; on the last one queue the result.
	function automatic void absorb_char(input logic [7:0] c, input logic last);
		logic    is_digit;
		int      d;
		int      v;
		int      e;
		logic    taken;
		result_t want;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d = is_digit ? int'(c - CH_ZERO) : 0;
		taken = 1'b0;
		if (scan_mode == PH_START) begin
			scan_mode = PH_INT;
			if (c == CH_MINUS) begin
				minus_lead = 1'b1;
				taken = 1'b1;
			end
		end
		if (!taken) begin
			if (scan_mode == PH_EXP) begin
				if (is_digit) begin
					v = exp_val * 10 + d;
					exp_val = (v > EXP_LIMIT) ? EXP_LIMIT : v;
					exp_sign_ok = 1'b0;
				end else if (exp_sign_ok && (c == CH_PLUS || c == CH_MINUS)) begin
					if (c == CH_MINUS) exp_minus = 1'b1;
					exp_sign_ok = 1'b0;
				end else begin
					bad_seen = 1'b1;
				end
			end else if (is_digit) begin
				add_mant_digit(d, scan_mode == PH_FRAC);
			end else if (c == CH_POINT && scan_mode == PH_INT) begin
				scan_mode = PH_FRAC;
			end else if (c == CH_E_LO || c == CH_E_UP) begin
				scan_mode = PH_EXP;
				exp_sign_ok = 1'b1;
			end else begin
				bad_seen = 1'b1;
			end
		end
		if (last) begin
			// marker with nothing after it
			if (scan_mode == PH_EXP && exp_sign_ok) bad_seen = 1'b1;
			e = exp_minus ? -exp_val : exp_val;
			e = e + drop_cnt - frac_cnt;
			if (e > 32767) e = 32767;
			if (e < -32768) e = -32768;
			want.negative = minus_lead;
			want.mantissa = mant_acc;
			want.dec_exponent = e[15:0];
			want.malformed = bad_seen;
			want.inexact = lost_seen;
			result_q.push_back(want);
			clear_scan();
		end
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic void check_result(input logic [87:0] word);
		result_t got;
		result_t want;
		got = result_t'(word[82:0]);
		if (result_q.size() == 0) begin
			$display("%0t: unexpected result word: expected none, actual %h", $time, word);
			mismatch_count++;
		end else begin
			want = result_q.pop_front();
			compare_field("negative", 64'(want.negative), 64'(got.negative));
			compare_field("mantissa", want.mantissa, got.mantissa);
			compare_field("dec_exponent", 64'(want.dec_exponent), 64'(got.dec_exponent));
			compare_field("malformed", 64'(want.malformed), 64'(got.malformed));
			compare_field("inexact", 64'(want.inexact), 64'(got.inexact));
			compare_field("pad", 64'd0, 64'(word[87:83]));
		end
	endfunction

	// Sender: presents queued words, random gaps, optional drain before a held word.
	int   gap_left = 0;
	int   sent_cnt = 0;
	logic drv_jitter = 1'b1;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				absorb_char(feed_q[0].ch, feed_q[0].last);
				void'(feed_q.pop_front());
				sent_cnt++;
				if (sent_cnt % 100 == 0) drv_jitter = ($urandom_range(0, 3) != 0);
			end
			quiet_tail <= (feed_q.size() < CALM_ITEMS);
			if (s_tvalid && !s_tready) begin
				// word still on offer, hold it
			end else if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (feed_q.size() == 0 || (feed_q[0].hold && result_q.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else if (drv_jitter && feed_q.size() >= CALM_ITEMS &&
					$urandom_range(0, 3) == 0) begin
				s_tvalid <= 1'b0;
				gap_left = $urandom_range(0, 2);
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= feed_q[0].ch;
				s_tlast <= feed_q[0].last;
			end
		end
	end

	// Receiver: checks each result word, stalls in random bursts.
	int   stall_left = 0;
	int   mon_cycles = 0;
	logic mon_jitter = 1'b1;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) check_result(m_tdata);
			mon_cycles++;
			if (mon_cycles % 200 == 0) mon_jitter = ($urandom_range(0, 3) != 0);
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (mon_jitter && !quiet_tail && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic add_char(input logic [7:0] ch, input bit last, input bit hold);
		feed_t w;
		w.ch = ch;
		w.last = last;
		w.hold = hold;
		feed_q.push_back(w);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1, 1'b0);
	endtask

	task automatic flush_literal(input bit hold);
		for (int i = 0; i < lit_buf.size(); i++)
			add_char(lit_buf[i], i == lit_buf.size() - 1, hold && i == 0);
	endtask

	function automatic void put_digits(input int n);
		for (int i = 0; i < n; i++) lit_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	// mostly short digit runs, now and then past the mantissa capacity
	function automatic int pick_len();
		if ($urandom_range(0, 7) == 0) return $urandom_range(15, 24);
		return $urandom_range(0, 4);
	endfunction

	function automatic void build_clean();
		if ($urandom_range(0, 1) != 0) lit_buf.push_back(CH_MINUS);
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) lit_buf.push_back(CH_ZERO);
		put_digits(pick_len());
		if ($urandom_range(0, 1) != 0) begin
			lit_buf.push_back(CH_POINT);
			put_digits(pick_len());
		end
		if ($urandom_range(0, 2) == 0) begin
			lit_buf.push_back(($urandom_range(0, 1) != 0) ? CH_E_LO : CH_E_UP);
			case ($urandom_range(0, 2))
				0: lit_buf.push_back(CH_PLUS);
				1: lit_buf.push_back(CH_MINUS);
				default: ;
			endcase
			put_digits(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
		end
		if (lit_buf.size() == 0) put_digits(1);
	endfunction

	function automatic void build_literal();
		int roll;
		int pos;
		lit_buf.delete();
		roll = $urandom_range(0, 99);
		if (roll < 90) build_clean();
		if (roll >= 80 && roll < 90) begin
			// one character swapped for a stray one
			pos = $urandom_range(0, lit_buf.size() - 1);
			case ($urandom_range(0, 4))
				0: lit_buf[pos] = CH_POINT;
				1: lit_buf[pos] = CH_PLUS;
				2: lit_buf[pos] = CH_MINUS;
				3: lit_buf[pos] = CH_E_LO;
				default: lit_buf[pos] = 8'($urandom_range(0, 255));
			endcase
		end else if (roll >= 90) begin
			repeat ($urandom_range(1, 6)) lit_buf.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic add_random(input int n_items);
		int fed;
		int lit_no;
		fed = 0;
		lit_no = 0;
		while (fed < n_items) begin
			build_literal();
			flush_literal(lit_no % 40 == 0);
			fed += lit_buf.size();
			lit_no++;
		end
	endtask

	initial begin
		clear_scan();
		// directed
		add_text("7");
		add_text("-");
		add_text("+1-");
		add_text("0.05");
		add_text("1.2.3E-45");
		add_text("5e");
		add_text("9e1e+");
		add_char(8'h00, 1'b0, 1'b0);
		add_char(8'hFF, 1'b1, 1'b0);
		add_random(600);
		// integer digits well past the mantissa capacity
		lit_buf.delete();
		lit_buf.push_back(CH_ZERO + 8'd1);
		repeat (30) lit_buf.push_back(CH_NINE);
		lit_buf.push_back(CH_POINT);
		put_digits(3);
		flush_literal(1'b1);
		// long fraction with a large negative exponent
		lit_buf.delete();
		lit_buf.push_back(CH_MINUS);
		lit_buf.push_back(CH_ZERO);
		lit_buf.push_back(CH_POINT);
		put_digits(25);
		lit_buf.push_back(CH_E_LO);
		lit_buf.push_back(CH_MINUS);
		repeat (5) lit_buf.push_back(CH_NINE);
		flush_literal(1'b1);
		add_random(600);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (feed_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("decimal_number_scanner_test: done, clean");
		end else begin
			$display("decimal_number_scanner_test: done, errors");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("decimal_number_scanner_test: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/dns_pkg.sv
hw/rtl/dns_in_reg.sv
hw/rtl/dns_scan.sv
hw/rtl/dns_out_reg.sv
hw/rtl/decimal_number_scanner.sv
hw/rtl/dns_checker.sv
tb/decimal_number_scanner_test.sv
